[rtl/core/ssd_pkg.sv]
// Shared types, codes and glyph tables of the seven-segment scan driver.
`timescale 1ns / 1ps
`default_nettype none

package ssd_pkg;

   // Operation codes carried in the op field of a request beat.
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_LEFT  = 2'd2;
   localparam logic [1:0] OP_RIGHT = 2'd3;

   // Register indexes of the control and status port.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLINK_EN_FIRST  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLINK_EN_SECOND = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLINK_THRESHOLD = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SET_CODE        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_INSTRUMENT      = 3'd4;

   // Segment bits, order dp g f e d c b a.
   localparam logic [7:0] SEG_MINUS = 8'h40;
   localparam logic [7:0] SEG_POINT = 8'h80;
   localparam logic [7:0] SEG_BLANK = 8'h00;

   // Reset values of the configuration registers.
   localparam logic [8:0]  THRESHOLD_RESET = 9'd250;
   localparam logic [31:0] SET_CODE_RESET  = 32'h7FFF_FFFF;

   typedef struct packed {
      logic [1:0]         op;
      logic               display_select;
      logic signed [31:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] scan_digit;
      logic       counter_reset;
      logic [7:0] segments_first;
      logic [7:0] segments_second;
      logic [1:0] cursor_position;
   } rsp_payload_type;

   // Configuration bundle handed from the register file to the control logic.
   typedef struct packed {
      logic        blink_en_first;
      logic        blink_en_second;
      logic [8:0]  blink_threshold;
      logic [31:0] set_code;
      logic        instrument;
   } cfg_type;

   // Decimal digit to segment byte.
   function automatic logic [7:0] digit_glyph(input logic [3:0] digit);
      logic [7:0] seg;
      unique case (digit)
         4'd0: seg = 8'h3F;
         4'd1: seg = 8'h06;
         4'd2: seg = 8'h5B;
         4'd3: seg = 8'h4F;
         4'd4: seg = 8'h66;
         4'd5: seg = 8'h6D;
         4'd6: seg = 8'h7D;
         4'd7: seg = 8'h07;
         4'd8: seg = 8'h7F;
         4'd9: seg = 8'h67;
         default: seg = SEG_BLANK;
      endcase
      return seg;
   endfunction

   // The -SEt- pattern, listed from position zero upward.
   function automatic logic [7:0] set_glyph(input logic [2:0] pos);
      logic [7:0] seg;
      unique case (pos)
         3'd0: seg = 8'h40;
         3'd1: seg = 8'h78;
         3'd2: seg = 8'h79;
         3'd3: seg = 8'h6D;
         3'd4: seg = 8'h40;
         default: seg = SEG_BLANK;
      endcase
      return seg;
   endfunction

endpackage

`default_nettype wire

[rtl/core/ssd_store.sv]
// Digit store: segment bytes of both displays in one synchronous memory.
`timescale 1ns / 1ps
`default_nettype none

module ssd_store #(
   parameter int unsigned DIGITS = 5
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            wr_en,
   input  wire logic [$clog2(2*DIGITS)-1:0]     wr_addr,
   input  wire logic [7:0]                      wr_data,
   input  wire logic                            rd_en,
   input  wire logic [$clog2(2*DIGITS)-1:0]     rd_addr_a,
   input  wire logic [$clog2(2*DIGITS)-1:0]     rd_addr_b,
   output logic [7:0]                           rd_data_a,
   output logic [7:0]                           rd_data_b
);

   localparam int unsigned DEPTH = 2 * DIGITS;

   logic [7:0]       mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [7:0]       rd_a_ff;
   logic [7:0]       rd_b_ff;

   // Entries read as segments off until first written after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // One write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= valid_ff[rd_addr_a] ? mem[rd_addr_a] : ssd_pkg::SEG_BLANK;
         rd_b_ff <= valid_ff[rd_addr_b] ? mem[rd_addr_b] : ssd_pkg::SEG_BLANK;
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

[rtl/core/ssd_div10.sv]
// Divide-by-ten step: reciprocal multiply, then quotient and remainder.
`timescale 1ns / 1ps
`default_nettype none

module ssd_div10 (
   input  wire logic        clock,
   input  wire logic        load,
   input  wire logic [31:0] dividend,
   output logic [31:0]      quotient,
   output logic [3:0]       remainder
);

   // ceil(2^35 / 10); exact quotient for every 32-bit dividend.
   localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;

   logic [31:0] dividend_ff;
   logic [63:0] prod_ff;
   logic [31:0] times_ten;
   logic [31:0] diff;

   // The product is registered before the remainder is formed.
   always_ff @(posedge clock) begin
      if (load) begin
         dividend_ff <= dividend;
         prod_ff     <= dividend * RECIP_TEN;
      end
   end

   always_comb begin
      quotient  = 32'(prod_ff[63:35]);
      times_ten = {quotient[28:0], 3'b000} + {quotient[30:0], 1'b0};
      diff      = dividend_ff - times_ten;
      remainder = diff[3:0];
   end

endmodule

`default_nettype wire

[rtl/core/ssd_ctrl.sv]
// Sequencer: number conversion, cursor moves, scan ticks and blink timing.
`timescale 1ns / 1ps
`default_nettype none

module ssd_ctrl #(
   parameter int unsigned DIGITS       = 5,
   parameter int unsigned BLINK_PERIOD = 500
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire ssd_pkg::cfg_type             cfg,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire ssd_pkg::req_payload_type     req_payload,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output ssd_pkg::rsp_payload_type          rsp_payload,
   output logic                              wr_en,
   output logic [$clog2(2*DIGITS)-1:0]       wr_addr,
   output logic [7:0]                        wr_data,
   output logic                              rd_en,
   output logic [$clog2(2*DIGITS)-1:0]       rd_addr_a,
   output logic [$clog2(2*DIGITS)-1:0]       rd_addr_b,
   input  wire logic [7:0]                   rd_data_a,
   input  wire logic [7:0]                   rd_data_b
);

   localparam int unsigned IW  = $clog2(DIGITS);
   localparam int unsigned AW  = $clog2(2 * DIGITS);
   localparam int unsigned PW  = $clog2(BLINK_PERIOD);
   localparam int unsigned CW  = (PW > 9) ? PW : 9;
   localparam int unsigned CURSOR_LIMIT = ((DIGITS - 2) < 3) ? (DIGITS - 2) : 3;
   localparam int unsigned SET_COUNT    = (DIGITS < 5) ? DIGITS : 5;
   localparam logic [1:0]    CURSOR_MAX = 2'(CURSOR_LIMIT);
   localparam logic [IW-1:0] TOP_POS    = IW'(DIGITS - 1);
   localparam logic [IW-1:0] SET_LAST   = IW'(SET_COUNT - 1);
   localparam logic [IW-1:0] POINT_POS  = IW'(3);
   localparam logic [PW-1:0] PHASE_LAST = PW'(BLINK_PERIOD - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SIGN,
      S_SET,
      S_MUL,
      S_DIG,
      S_TICK
   } state_type;

   state_type                 state_ff, state_in;
   logic [IW-1:0]             idx_ff, idx_in;
   logic                      disp_ff, disp_in;
   logic                      inst_ff, inst_in;
   logic                      is_set_ff, is_set_in;
   logic                      neg_ff, neg_in;
   logic [31:0]               mag_ff, mag_in;
   logic [IW-1:0]             pos_ff, pos_in;
   logic [PW-1:0]             phase_ff, phase_in;
   logic [1:0]                cursor_ff, cursor_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   ssd_pkg::rsp_payload_type  rsp_ff, rsp_in;

   logic                      div_load;
   logic [31:0]               div_quotient;
   logic [3:0]                div_remainder;
   logic [31:0]               value_bits;
   logic [IW-1:0]             dig_last;
   logic [1:0]                cur_first;
   logic [1:0]                cur_second;
   logic                      phase_over;
   logic                      blank_first;
   logic                      blank_second;

   function automatic logic [AW-1:0] entry_addr(input logic disp, input logic [IW-1:0] pos);
      logic [AW-1:0] addr;
      addr = disp ? (AW'(DIGITS) + AW'(pos)) : AW'(pos);
      return addr;
   endfunction

   ssd_div10 u_div10 (
      .clock     (clock),
      .load      (div_load),
      .dividend  (mag_ff),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign rd_addr_a   = entry_addr(1'b0, pos_ff);
   assign rd_addr_b   = entry_addr(1'b1, pos_ff);
   assign value_bits  = $unsigned(req_payload.value);

   // Blanking of the cursor digit in the second part of the blink period.
   always_comb begin
      cur_first    = (cfg.instrument == 1'b0) ? cursor_ff : 2'd0;
      cur_second   = (cfg.instrument == 1'b1) ? cursor_ff : 2'd0;
      phase_over   = CW'(phase_ff) > CW'(cfg.blink_threshold);
      blank_first  = cfg.blink_en_first && phase_over && (3'(cur_first) == 3'(pos_ff));
      blank_second = cfg.blink_en_second && phase_over && (3'(cur_second) == 3'(pos_ff));
      dig_last     = inst_ff ? IW'(DIGITS - 2) : TOP_POS;
   end

   // Next-state logic of the sequencer.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      disp_in      = disp_ff;
      inst_in      = inst_ff;
      is_set_in    = is_set_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      pos_in       = pos_ff;
      phase_in     = phase_ff;
      cursor_in    = cursor_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = entry_addr(disp_ff, idx_ff);
      wr_data      = ssd_pkg::SEG_BLANK;
      rd_en        = 1'b0;
      div_load     = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_payload.op)
                  ssd_pkg::OP_TICK: begin
                     rd_en    = 1'b1;
                     state_in = S_TICK;
                  end
                  ssd_pkg::OP_WRITE: begin
                     disp_in   = req_payload.display_select;
                     inst_in   = (req_payload.display_select == cfg.instrument);
                     neg_in    = value_bits[31];
                     mag_in    = value_bits[31] ? (32'd0 - value_bits) : value_bits;
                     is_set_in = (value_bits == cfg.set_code);
                     idx_in    = '0;
                     state_in  = S_SIGN;
                  end
                  ssd_pkg::OP_LEFT: begin
                     if (cursor_ff < CURSOR_MAX) begin
                        cursor_in = cursor_ff + 2'd1;
                     end
                  end
                  ssd_pkg::OP_RIGHT: begin
                     if (cursor_ff != 2'd0) begin
                        cursor_in = cursor_ff - 2'd1;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         // The top position first takes the sign; later writes may cover it.
         S_SIGN: begin
            wr_en    = 1'b1;
            wr_addr  = entry_addr(disp_ff, TOP_POS);
            wr_data  = neg_ff ? ssd_pkg::SEG_MINUS : ssd_pkg::SEG_BLANK;
            state_in = is_set_ff ? S_SET : S_MUL;
         end
         S_SET: begin
            wr_en   = 1'b1;
            wr_data = ssd_pkg::set_glyph(3'(idx_ff));
            if (idx_ff == SET_LAST) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         S_MUL: begin
            div_load = 1'b1;
            state_in = S_DIG;
         end
         // One decimal digit per pass; the instrument display gets a point
         // on position three and keeps its top position for the sign.
         S_DIG: begin
            wr_en   = 1'b1;
            wr_data = ssd_pkg::digit_glyph(div_remainder)
                    | ((inst_ff && (idx_ff == POINT_POS)) ? ssd_pkg::SEG_POINT
                                                          : ssd_pkg::SEG_BLANK);
            mag_in  = div_quotient;
            if (idx_ff == dig_last) begin
               state_in = S_IDLE;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = S_MUL;
            end
         end
         // Store data is ready; wait for the output register to free up.
         S_TICK: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_in.scan_digit      = 3'(pos_ff);
               rsp_in.counter_reset   = (pos_ff == '0);
               rsp_in.segments_first  = blank_first ? ssd_pkg::SEG_BLANK : rd_data_a;
               rsp_in.segments_second = blank_second ? ssd_pkg::SEG_BLANK : rd_data_b;
               rsp_in.cursor_position = cursor_ff;
               pos_in   = (pos_ff == TOP_POS) ? '0 : pos_ff + IW'(1);
               phase_in = (phase_ff == PHASE_LAST) ? '0 : phase_ff + PW'(1);
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         phase_ff     <= '0;
         cursor_ff    <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         phase_ff     <= phase_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff    <= idx_in;
      disp_ff   <= disp_in;
      inst_ff   <= inst_in;
      is_set_ff <= is_set_in;
      neg_ff    <= neg_in;
      mag_ff    <= mag_in;
      rsp_ff    <= rsp_in;
   end

   // The store is only written by the number conversion states.
   a_write_in_conversion: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_SIGN || state_ff == S_SET || state_ff == S_DIG))
      else $error("digit store written outside a number conversion");

   // A tick beat is followed by the state that delivers its result.
   a_tick_delivers: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_payload.op == ssd_pkg::OP_TICK)
      |=> (state_ff == S_TICK))
      else $error("scan tick not followed by result stage");

   // The cursor never leaves its range.
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= CURSOR_MAX)
      else $error("cursor beyond its last position");

   // The restart flag marks exactly position zero.
   a_counter_reset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.counter_reset == (rsp_ff.scan_digit == 3'd0)))
      else $error("counter restart flag disagrees with scan digit");

   // Each conversion pass multiplies before it writes a digit.
   a_mul_before_digit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIG) |-> ($past(state_ff) == S_MUL))
      else $error("digit written without a fresh quotient");

endmodule

`default_nettype wire

[rtl/core/seven_segment_scan_driver_top.sv]
// Top level of the seven-segment scan driver with its register file.
`timescale 1ns / 1ps
`default_nettype none

// Two multiplexed displays of DIGITS digits share one scan. Request beats
// carry a scan tick, a number write or a cursor move; only a scan tick
// returns a response beat, holding both displays' segment bytes for the
// current position. The segment bytes live in one synchronous memory of
// 2*DIGITS bytes with one write port. The block takes one request at a
// time: a cursor move only updates the cursor, a scan tick passes the
// memory read, then the response register, which may wait for the output
// to be taken, and a number write passes the sign write, then one write
// per -SEt- glyph or, per decimal digit, the divide-by-ten multiplier and
// then the memory write port. The memory reads as all segments off after
// reset, with no clearing pass. Registers are to be written through the
// csr port only while the block is idle; the block does not enforce this.
module seven_segment_scan_driver_top #(
   parameter int unsigned DIGITS       = 5,
   parameter int unsigned BLINK_PERIOD = 500
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire ssd_pkg::req_payload_type            req_payload,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output ssd_pkg::rsp_payload_type                 rsp_payload,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [ssd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [31:0]                         csr_data
);

   localparam int unsigned AW = $clog2(2 * DIGITS);

   ssd_pkg::cfg_type cfg_ff;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [7:0]       wr_data;
   logic             rd_en;
   logic [AW-1:0]    rd_addr_a;
   logic [AW-1:0]    rd_addr_b;
   logic [7:0]       rd_data_a;
   logic [7:0]       rd_data_b;

   assign csr_ready = 1'b1;

   // Configuration registers; writes to unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blink_en_first  <= 1'b0;
         cfg_ff.blink_en_second <= 1'b0;
         cfg_ff.blink_threshold <= ssd_pkg::THRESHOLD_RESET;
         cfg_ff.set_code        <= ssd_pkg::SET_CODE_RESET;
         cfg_ff.instrument      <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ssd_pkg::CSR_BLINK_EN_FIRST:  cfg_ff.blink_en_first  <= csr_data[0];
            ssd_pkg::CSR_BLINK_EN_SECOND: cfg_ff.blink_en_second <= csr_data[0];
            ssd_pkg::CSR_BLINK_THRESHOLD: cfg_ff.blink_threshold <= csr_data[8:0];
            ssd_pkg::CSR_SET_CODE:        cfg_ff.set_code        <= csr_data;
            ssd_pkg::CSR_INSTRUMENT:      cfg_ff.instrument      <= csr_data[0];
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   ssd_ctrl #(
      .DIGITS       (DIGITS),
      .BLINK_PERIOD (BLINK_PERIOD)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr_a   (rd_addr_a),
      .rd_addr_b   (rd_addr_b),
      .rd_data_a   (rd_data_a),
      .rd_data_b   (rd_data_b)
   );

   ssd_store #(
      .DIGITS (DIGITS)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

endmodule

`default_nettype wire

[verif/tb_seven_segment_scan_driver_top.sv]
// Self-checking testbench of the seven-segment scan driver: directed and random beats.
`timescale 1ns / 1ps

module tb_seven_segment_scan_driver_top;

   localparam int unsigned DIGITS       = 5;
   localparam int unsigned BLINK_PERIOD = 500;
   localparam int unsigned CURSOR_MAX   = (DIGITS - 2) < 3 ? (DIGITS - 2) : 3;
   // Index past the register list; writes to it must change nothing.
   localparam logic [ssd_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int unsigned PHASES       = 8;
   localparam int unsigned PHASE_ITEMS  = 125;
   localparam int unsigned HOLD_CYCLES  = 200;
   localparam int unsigned SETTLE_CYCLES = 24;
   localparam int unsigned STALL_LIMIT  = 2000;

   // Predicts the response beat of every scan tick from the beats accepted so far.
   class segment_scoreboard;
      bit          blink_en [2];
      bit [8:0]    threshold;
      bit [31:0]   set_code;
      bit          instrument;
      bit [7:0]    segment_store [2][DIGITS];
      bit [7:0]    numeral_seg [10];
      bit [7:0]    set_seg [5];
      bit [2:0]    scan_pos;
      int unsigned blink_count;
      bit [1:0]    cursor;
      ssd_pkg::rsp_payload_type expected_scans [$];
      int unsigned errors;

      function new();
         blink_en[0] = 1'b0;
         blink_en[1] = 1'b0;
         threshold = ssd_pkg::THRESHOLD_RESET;
         set_code = ssd_pkg::SET_CODE_RESET;
         instrument = 1'b1;
         for (int d = 0; d < 2; d++) begin
            for (int i = 0; i < DIGITS; i++) segment_store[d][i] = ssd_pkg::SEG_BLANK;
         end
         numeral_seg = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                         8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h67};
         // The -SEt- pattern from position zero upward.
         set_seg = '{8'h40, 8'h78, 8'h79, 8'h6D, 8'h40};
         scan_pos = '0;
         blink_count = 0;
         cursor = '0;
         errors = 0;
      endfunction

      function int pending();
         return expected_scans.size();
      endfunction

      function void write_register(logic [ssd_pkg::CSR_INDEX_W-1:0] index,
                                   logic [31:0] data);
         case (index)
            ssd_pkg::CSR_BLINK_EN_FIRST:  blink_en[0] = data[0];
            ssd_pkg::CSR_BLINK_EN_SECOND: blink_en[1] = data[0];
            ssd_pkg::CSR_BLINK_THRESHOLD: threshold = data[8:0];
            ssd_pkg::CSR_SET_CODE:        set_code = data;
            ssd_pkg::CSR_INSTRUMENT:      instrument = data[0];
            default: ;
         endcase
      endfunction

      // Converts a number into the segment bytes of one display.
      function void store_number(bit disp, bit [31:0] v);
         bit        neg;
         bit        inst;
         bit [31:0] mag;
         bit [7:0]  seg;
         neg = v[31];
         inst = (disp == instrument);
         mag = neg ? (32'd0 - v) : v;
         segment_store[disp][DIGITS-1] = neg ? ssd_pkg::SEG_MINUS : ssd_pkg::SEG_BLANK;
         if (v == set_code) begin
            for (int i = 0; i < 5 && i < DIGITS; i++) segment_store[disp][i] = set_seg[i];
            return;
         end
         // The instrument display keeps its top position for the sign only.
         for (int i = 0; i < DIGITS; i++) begin
            if (!(i == DIGITS - 1 && inst)) begin
               seg = numeral_seg[mag % 10];
               if (i == 3 && inst) seg = seg | ssd_pkg::SEG_POINT;
               segment_store[disp][i] = seg;
               mag = mag / 10;
            end
         end
      endfunction

      // Byte shown on one display at the current position, with cursor blanking.
      function bit [7:0] shown_byte(bit disp, bit enable);
         bit [2:0] cur;
         cur = (disp == instrument) ? {1'b0, cursor} : 3'd0;
         if (enable && cur == scan_pos && blink_count > threshold) begin
            return ssd_pkg::SEG_BLANK;
         end
         return segment_store[disp][scan_pos];
      endfunction

      function void note_request(ssd_pkg::req_payload_type p);
         ssd_pkg::rsp_payload_type scan;
         case (p.op)
            ssd_pkg::OP_WRITE: store_number(p.display_select, p.value);
            ssd_pkg::OP_LEFT:  if (cursor < CURSOR_MAX) cursor = cursor + 1'b1;
            ssd_pkg::OP_RIGHT: if (cursor > 0) cursor = cursor - 1'b1;
            ssd_pkg::OP_TICK: begin
               scan.scan_digit = scan_pos;
               scan.counter_reset = (scan_pos == 0);
               scan.segments_first = shown_byte(1'b0, blink_en[0]);
               scan.segments_second = shown_byte(1'b1, blink_en[1]);
               scan.cursor_position = cursor;
               expected_scans.push_back(scan);
               scan_pos = (scan_pos == DIGITS - 1) ? 3'd0 : scan_pos + 3'd1;
               blink_count = (blink_count + 1) % BLINK_PERIOD;
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string label, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h",
                     $time, label, want, got);
         end
      endfunction

      function void check_response(ssd_pkg::rsp_payload_type got);
         ssd_pkg::rsp_payload_type want;
         if (expected_scans.size() == 0) begin
            errors++;
            $display("%0t: response beat with nothing expected, expected none, actual 'h%0h",
                     $time, got);
            return;
         end
         want = expected_scans.pop_front();
         compare_field("scan_digit", 32'(want.scan_digit), 32'(got.scan_digit));
         compare_field("counter_reset", 32'(want.counter_reset), 32'(got.counter_reset));
         compare_field("segments_first", 32'(want.segments_first),
                       32'(got.segments_first));
         compare_field("segments_second", 32'(want.segments_second),
                       32'(got.segments_second));
         compare_field("cursor_position", 32'(want.cursor_position),
                       32'(got.cursor_position));
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   ssd_pkg::req_payload_type        req_payload = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   ssd_pkg::rsp_payload_type        rsp_payload;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [ssd_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0]                     csr_data = '0;

   segment_scoreboard sb;
   bit          calm = 1'b0;
   bit          hold_request = 1'b0;
   int unsigned hold_left = 0;
   int unsigned stall_cycles = 0;

   seven_segment_scan_driver_top #(
      .DIGITS(DIGITS),
      .BLINK_PERIOD(BLINK_PERIOD)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response side: check each beat, stall at random or for a long hold-off.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_payload);
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 6);
      end
   end

   // Ends the run when no beat moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
         $display("[seven_segment_scan_driver_top] ERROR");
         $finish;
      end
   end

   function automatic ssd_pkg::req_payload_type make_req(logic [1:0] op, bit disp,
                                                         logic [31:0] v);
      ssd_pkg::req_payload_type p;
      p.op = op;
      p.display_select = disp;
      p.value = v;
      return p;
   endfunction

   function automatic logic [31:0] with_noise(bit b);
      logic [31:0] r;
      r = $urandom;
      r[0] = b;
      return r;
   endfunction

   function automatic bit coin();
      return 1'($urandom_range(1, 0));
   endfunction

   // Mostly scan ticks; writes aim at the set code, extremes, short numbers and random values.
   function automatic ssd_pkg::req_payload_type random_request();
      ssd_pkg::req_payload_type p;
      int unsigned              pick;
      p.display_select = coin();
      p.value = $urandom;
      pick = $urandom_range(99);
      if (pick < 55) p.op = ssd_pkg::OP_TICK;
      else if (pick < 80) p.op = ssd_pkg::OP_WRITE;
      else if (pick < 90) p.op = ssd_pkg::OP_LEFT;
      else p.op = ssd_pkg::OP_RIGHT;
      if (p.op == ssd_pkg::OP_WRITE) begin
         case ($urandom_range(5))
            0: p.value = sb.set_code;
            1: p.value = int'($urandom_range(199998)) - 99999;
            2: p.value = int'($urandom_range(19998)) - 9999;
            3: begin
               case ($urandom_range(3))
                  0: p.value = 32'h8000_0000;
                  1: p.value = 32'h7FFF_FFFF;
                  2: p.value = 32'h0000_0000;
                  default: p.value = 32'hFFFF_FFFF;
               endcase
            end
            default: ;
         endcase
      end
      return p;
   endfunction

   // Offers one request beat and returns at the edge that accepts it.
   task automatic send_req(input ssd_pkg::req_payload_type p);
      if (!calm && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (!calm && $urandom_range(99) < 6);
      end
      req_valid <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(p);
   endtask

   task automatic req_idle();
      req_valid <= 1'b0;
   endtask

   task automatic wait_scans_done();
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Drains all scans, then lets a number write still in flight finish.
   task automatic settle();
      wait_scans_done();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [ssd_pkg::CSR_INDEX_W-1:0] index,
                            input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_register(index, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // The first settings hit the extremes; later ones are random.
   task automatic apply_setting(input int unsigned step);
      bit          en_first;
      bit          en_second;
      bit          inst;
      logic [31:0] thr_data;
      logic [31:0] code;
      en_first = coin();
      en_second = coin();
      inst = coin();
      thr_data = $urandom;
      code = $urandom;
      case (step)
         0: begin
            en_first = 1'b1; en_second = 1'b1; thr_data = 32'd0;
            code = 32'h8000_0000; inst = 1'b0;
         end
         1: begin
            en_first = 1'b1; en_second = 1'b0; thr_data = BLINK_PERIOD - 1;
            code = 32'd0; inst = 1'b1;
         end
         2: begin
            en_first = 1'b0; en_second = 1'b1; thr_data = 32'hFFFF_FFFF;
            code = 32'h7FFF_FFFF; inst = 1'b0;
            write_csr(CSR_UNUSED, $urandom);
         end
         3: begin
            en_first = 1'b1; en_second = 1'b1; thr_data = BLINK_PERIOD - 2;
            inst = 1'b1;
         end
         4: begin
            en_first = 1'b1; en_second = 1'b1; thr_data = ssd_pkg::THRESHOLD_RESET;
            code = 32'hFFFF_FFFF; inst = 1'b0;
         end
         default: ;
      endcase
      write_csr(ssd_pkg::CSR_BLINK_EN_FIRST, with_noise(en_first));
      write_csr(ssd_pkg::CSR_BLINK_EN_SECOND, with_noise(en_second));
      write_csr(ssd_pkg::CSR_BLINK_THRESHOLD, thr_data);
      write_csr(ssd_pkg::CSR_SET_CODE, code);
      write_csr(ssd_pkg::CSR_INSTRUMENT, with_noise(inst));
   endtask

   initial begin
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats under reset settings: empty store, sign, set pattern,
      // most negative value, digit over the sign, and cursor saturation.
      repeat (2) send_req(make_req(ssd_pkg::OP_TICK, coin(), $urandom));
      send_req(make_req(ssd_pkg::OP_WRITE, 1'b1, 32'hFFFF_FFFF));
      send_req(make_req(ssd_pkg::OP_WRITE, 1'b0, 32'h7FFF_FFFF));
      repeat (5) send_req(make_req(ssd_pkg::OP_TICK, coin(), $urandom));
      send_req(make_req(ssd_pkg::OP_WRITE, 1'b1, 32'h8000_0000));
      send_req(make_req(ssd_pkg::OP_WRITE, 1'b0, -32'sd12345));
      repeat (5) send_req(make_req(ssd_pkg::OP_TICK, coin(), $urandom));
      repeat (4) send_req(make_req(ssd_pkg::OP_LEFT, coin(), $urandom));
      send_req(make_req(ssd_pkg::OP_TICK, coin(), $urandom));
      repeat (4) send_req(make_req(ssd_pkg::OP_RIGHT, coin(), $urandom));
      send_req(make_req(ssd_pkg::OP_TICK, coin(), $urandom));
      req_idle();
      settle();

      // Random beats under a new register setting in each phase.
      for (int unsigned s = 0; s < PHASES; s++) begin
         apply_setting(s);
         calm = (s == 2);
         for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
            send_req(random_request());
            if (s == 5 && k == PHASE_ITEMS / 2) begin
               req_idle();
               wait_scans_done();
            end
         end
         if (s == 3) begin
            // Hold off the response side while ticks keep coming.
            hold_request = 1'b1;
            repeat (30) send_req(make_req(ssd_pkg::OP_TICK, coin(), $urandom));
         end
         calm = 1'b0;
         req_idle();
         settle();
      end

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[seven_segment_scan_driver_top] OK");
      end else begin
         $display("[seven_segment_scan_driver_top] ERROR");
      end
      $finish;
   end

endmodule
